>>> rtl/ssevl_pkg.sv
// Shared types and constants for the sorted sound effect voice list.
`default_nettype none
package ssevl_pkg;

    localparam int LIST_DEPTH_DEF = 8;
    localparam int FRAME_W        = 16;
    localparam int STATUS_W       = 3;
    localparam int COUNT_W        = 4;

    localparam logic CMD_PLAY = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_NO_SLOT   = 3'd4,
        ST_TICK      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_INSERT,
        OP_REPLACE,
        OP_REMOVE,
        OP_ADVANCE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] cur_frame;
        logic [FRAME_W-1:0] end_frame;
    } t_entry;

    typedef struct packed {
        logic ins_seen;
        logic rem_seen;
    } t_chain;

    typedef struct packed {
        logic               command;
        logic [FRAME_W-1:0] start_frame;
        logic [FRAME_W-1:0] end_frame;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  active_count;
        logic [FRAME_W-1:0]  head_current;
        logic [FRAME_W-1:0]  head_end;
    } t_out;

endpackage
`default_nettype wire

>>> rtl/sorted_sound_effect_voice_list.sv
// Top level of the sorted sound effect voice list: slot chain, sequencer, result register.
//
// Input channel: i_valid / o_stall with payload i_data (command, start_frame,
// end_frame); a transfer happens at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with payload o_data (status, active_count,
// head_current, head_end); one result per accepted item.
// Configuration: i_cfg_we writes i_cfg_data into the ignore threshold at the edge.
// A play request is settled in the transfer cycle by the slot chain and its
// status passes through the report state into the output register.
// A tick removes one finished entry per cycle, front first, then advances all
// survivors together before the report state. The next item is taken once the
// result is in the output register, so no new item is taken while one is in progress.
// While the receiver stalls the result holds in o_data; one further item may be
// accepted and processed, its result waiting until the output register frees.
// Synchronous reset empties the list, clears the threshold and drops o_valid.
`default_nettype none
module sorted_sound_effect_voice_list #(
    parameter int LIST_DEPTH = ssevl_pkg::LIST_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  ssevl_pkg::t_in               i_data,
    output logic                         o_valid,
    input  wire                          i_stall,
    output ssevl_pkg::t_out              o_data,
    input  wire                          i_cfg_we,
    input  wire [ssevl_pkg::FRAME_W-1:0] i_cfg_data
);
    import ssevl_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    t_status              r_status;
    t_status              n_status;
    logic [FRAME_W-1:0]   r_threshold;
    logic                 r_out_valid;
    t_out                 r_out;
    t_cell_op             cell_op;
    logic                 accept;
    logic                 load_out;

    t_entry               w_entry [LIST_DEPTH];
    t_chain               w_chain [LIST_DEPTH+1];
    logic [LIST_DEPTH-1:0] w_dup;
    logic [LIST_DEPTH-1:0] w_valid;
    t_entry               empty_entry;

    assign empty_entry = '0;
    assign w_chain[0]  = '0;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_entry prev_e;
        t_entry next_e;
        if (g == 0) begin : g_first
            assign prev_e = empty_entry;
        end else begin : g_mid
            assign prev_e = w_entry[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign next_e = empty_entry;
        end else begin : g_inner
            assign next_e = w_entry[g+1];
        end
        ssevl_cell #(
            .HEAD (g == 0)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (cell_op),
            .i_req_start (i_data.start_frame),
            .i_req_end   (i_data.end_frame),
            .i_prev      (prev_e),
            .i_next      (next_e),
            .i_chain     (w_chain[g]),
            .o_chain     (w_chain[g+1]),
            .o_entry     (w_entry[g]),
            .o_dup       (w_dup[g])
        );
        assign w_valid[g] = w_entry[g].valid;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign load_out = (r_state == S_REPORT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = r_status;
        cell_op  = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_data.command == CMD_TICK) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_REPORT;
                        priority if (w_valid[0] && (i_data.end_frame <= r_threshold)) begin
                            n_status = ST_IGNORED;
                        end else if (w_valid[0] && (w_entry[0].end_frame <= r_threshold)) begin
                            n_status = ST_REPLACED;
                            cell_op  = OP_REPLACE;
                        end else if (|w_dup) begin
                            n_status = ST_DUPLICATE;
                        end else if (!w_chain[LIST_DEPTH].ins_seen) begin
                            n_status = ST_NO_SLOT;
                        end else begin
                            n_status = ST_INSERTED;
                            cell_op  = OP_INSERT;
                            if (r_count != CNT_W'(LIST_DEPTH)) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            S_SWEEP: begin
                if (w_chain[LIST_DEPTH].rem_seen) begin
                    cell_op = OP_REMOVE;
                    n_count = r_count - CNT_W'(1);
                end else begin
                    cell_op  = OP_ADVANCE;
                    n_status = ST_TICK;
                    n_state  = S_REPORT;
                end
            end
            S_REPORT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= ST_INSERTED;
            r_threshold <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.status       <= r_status;
            r_out.active_count <= COUNT_W'(r_count);
            r_out.head_current <= w_valid[0] ? w_entry[0].cur_frame : '0;
            r_out.head_end     <= w_valid[0] ? w_entry[0].end_frame : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("entry count disagrees with occupied slots");

    a_slots_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + LIST_DEPTH'(1))) == '0)
        else $error("occupied slots are not packed towards the head");

    a_sweep_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |=> (r_count <= $past(r_count)))
        else $error("count grew during a tick sweep");

    a_report_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_valid && (r_state == S_IDLE)))
        else $error("result not presented after report");

endmodule
`default_nettype wire

>>> rtl/ssevl_cell.sv
// One list slot: holds an entry and shifts it to or from its neighbours.
`default_nettype none
module ssevl_cell #(
    parameter bit HEAD = 1'b0
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  ssevl_pkg::t_cell_op         i_op,
    input  wire [ssevl_pkg::FRAME_W-1:0] i_req_start,
    input  wire [ssevl_pkg::FRAME_W-1:0] i_req_end,
    input  ssevl_pkg::t_entry           i_prev,
    input  ssevl_pkg::t_entry           i_next,
    input  ssevl_pkg::t_chain           i_chain,
    output ssevl_pkg::t_chain           o_chain,
    output ssevl_pkg::t_entry           o_entry,
    output logic                        o_dup
);
    import ssevl_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   gt;
    logic   is_pos;
    logic   done;

    always_comb begin
        gt       = r_entry.valid && (r_entry.end_frame > i_req_end);
        is_pos   = !i_chain.ins_seen && !gt;
        done     = r_entry.valid && (r_entry.cur_frame == r_entry.end_frame);
        o_chain.ins_seen = i_chain.ins_seen || !gt;
        o_chain.rem_seen = i_chain.rem_seen || done;
        o_dup    = is_pos && r_entry.valid && (r_entry.end_frame == i_req_end);
        n_entry  = r_entry;
        unique case (i_op)
            OP_NOP: begin
            end
            OP_INSERT: begin
                if (i_chain.ins_seen) begin
                    n_entry = i_prev;
                end else if (!gt) begin
                    n_entry.valid     = 1'b1;
                    n_entry.cur_frame = i_req_start;
                    n_entry.end_frame = i_req_end;
                end
            end
            OP_REPLACE: begin
                if (HEAD) begin
                    n_entry.cur_frame = i_req_start;
                    n_entry.end_frame = i_req_end;
                end
            end
            OP_REMOVE: begin
                if (i_chain.rem_seen || done) begin
                    n_entry = i_next;
                end
            end
            OP_ADVANCE: begin
                if (r_entry.valid) begin
                    n_entry.cur_frame = r_entry.cur_frame + FRAME_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.cur_frame <= n_entry.cur_frame;
        r_entry.end_frame <= n_entry.end_frame;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

>>> tb/tb_sorted_sound_effect_voice_list.sv
// Testbench for the sorted sound effect voice list: directed table, random phases, predictor.
module tb_sorted_sound_effect_voice_list;
    timeunit 1ns;
    timeprecision 1ps;

    import ssevl_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int SETTLE      = DEPTH + 4;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 105;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_CAP   = 100;

    typedef enum logic {
        ROW_ITEM,
        ROW_THRESH
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        t_in                item;
        bit                 has_exp;
        t_out               exp_res;
        logic [FRAME_W-1:0] thresh;
    } t_dir_row;

    typedef enum logic [1:0] {
        SM_OPEN,
        SM_RANDOM,
        SM_EVERY_THIRD,
        SM_BURSTS
    } t_stall_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_in                i_data;
    logic               o_valid;
    logic               i_stall;
    t_out               o_data;
    logic               i_cfg_we;
    logic [FRAME_W-1:0] i_cfg_data;

    logic [FRAME_W-1:0] voice_cur [DEPTH];
    logic [FRAME_W-1:0] voice_end [DEPTH];
    int                 voice_cnt;
    logic [FRAME_W-1:0] voice_thresh;

    t_out        expected_voice_q [$];
    t_out        voice_exp;
    t_dir_row    dir_table [$];
    int          mismatch_cnt;
    int          cycle_cnt;
    int          burst_left;
    t_stall_mode stall_mode;
    int          stall_mode_left;
    int          stall_run;
    int          stall_phase;

    sorted_sound_effect_voice_list #(
        .LIST_DEPTH(DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_out step_voice_list(t_in d);
        int      pos;
        int      k;
        bit      stop;
        t_status st;
        t_out    res;
        if (d.command == CMD_TICK) begin
            pos = 0;
            while (pos < voice_cnt) begin
                if (voice_cur[pos] == voice_end[pos]) begin
                    for (k = pos; k < DEPTH - 1; k++) begin
                        voice_cur[k] = voice_cur[k + 1];
                        voice_end[k] = voice_end[k + 1];
                    end
                    voice_cur[DEPTH - 1] = '0;
                    voice_end[DEPTH - 1] = '0;
                    voice_cnt--;
                end else begin
                    voice_cur[pos] = voice_cur[pos] + 16'd1;
                    pos++;
                end
            end
            st = ST_TICK;
        end else if (voice_cnt > 0 && d.end_frame <= voice_thresh) begin
            st = ST_IGNORED;
        end else if (voice_cnt > 0 && voice_end[0] <= voice_thresh) begin
            voice_cur[0] = d.start_frame;
            voice_end[0] = d.end_frame;
            st = ST_REPLACED;
        end else begin
            pos  = 0;
            stop = 1'b0;
            st   = ST_INSERTED;
            while (!stop && pos < voice_cnt) begin
                if (voice_end[pos] == d.end_frame) begin
                    st   = ST_DUPLICATE;
                    stop = 1'b1;
                end else if (voice_end[pos] < d.end_frame) begin
                    stop = 1'b1;
                end else begin
                    pos++;
                end
            end
            if (st == ST_INSERTED && pos >= DEPTH)
                st = ST_NO_SLOT;
            if (st == ST_INSERTED) begin
                for (k = DEPTH - 1; k > pos; k--) begin
                    voice_cur[k] = voice_cur[k - 1];
                    voice_end[k] = voice_end[k - 1];
                end
                voice_cur[pos] = d.start_frame;
                voice_end[pos] = d.end_frame;
                if (voice_cnt < DEPTH)
                    voice_cnt++;
            end
        end
        res.status       = st;
        res.active_count = COUNT_W'(voice_cnt);
        res.head_current = (voice_cnt > 0) ? voice_cur[0] : '0;
        res.head_end     = (voice_cnt > 0) ? voice_end[0] : '0;
        return res;
    endfunction

    function automatic t_dir_row item_row(logic cmd, logic [FRAME_W-1:0] s,
                                          logic [FRAME_W-1:0] e);
        t_dir_row r;
        r.kind             = ROW_ITEM;
        r.item.command     = cmd;
        r.item.start_frame = s;
        r.item.end_frame   = e;
        r.has_exp          = 1'b0;
        r.exp_res          = '0;
        r.thresh           = '0;
        return r;
    endfunction

    function automatic t_dir_row thresh_row(logic [FRAME_W-1:0] v);
        t_dir_row r;
        r        = item_row(CMD_PLAY, '0, '0);
        r.kind   = ROW_THRESH;
        r.thresh = v;
        return r;
    endfunction

    function automatic t_dir_row known(t_dir_row r, t_status st, int cnt,
                                       logic [FRAME_W-1:0] hc, logic [FRAME_W-1:0] he);
        t_dir_row q;
        q                      = r;
        q.has_exp              = 1'b1;
        q.exp_res.status       = st;
        q.exp_res.active_count = COUNT_W'(cnt);
        q.exp_res.head_current = hc;
        q.exp_res.head_end     = he;
        return q;
    endfunction

    function automatic t_in voice_request(logic [FRAME_W-1:0] base, int span);
        t_in d;
        int  r;
        d.start_frame = 16'($urandom);
        d.end_frame   = 16'($urandom);
        r             = $urandom_range(0, 99);
        if (r < 40) begin
            d.command = CMD_TICK;
        end else begin
            d.command = CMD_PLAY;
            if ($urandom_range(0, 9) != 0)
                d.end_frame = base + 16'($urandom_range(0, span));
            r = $urandom_range(0, 99);
            if (r < 70)
                d.start_frame = d.end_frame - 16'($urandom_range(0, 8));
            else if (r < 85)
                d.start_frame = d.end_frame - 16'($urandom_range(0, 60));
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_cnt < PRINT_CAP)
            $display("tb: mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic send_item(t_in d, bit has_exp, t_out exp_res);
        t_out predicted;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid = 1'b1;
        i_data  = d;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predicted = step_voice_list(d);
        expected_voice_q.push_back(has_exp ? exp_res : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [FRAME_W-1:0] v);
        i_valid = 1'b0;
        while (expected_voice_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we     = 1'b1;
        i_cfg_data   = v;
        voice_thresh = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_voice_q.size() == 0) begin
                report_mismatch("unexpected transfer, status", o_data.status, -1);
            end else begin
                voice_exp = expected_voice_q.pop_front();
                if (o_data.status !== voice_exp.status)
                    report_mismatch("status", o_data.status, voice_exp.status);
                if (o_data.active_count !== voice_exp.active_count)
                    report_mismatch("active_count", o_data.active_count,
                                    voice_exp.active_count);
                if (o_data.head_current !== voice_exp.head_current)
                    report_mismatch("head_current", o_data.head_current,
                                    voice_exp.head_current);
                if (o_data.head_end !== voice_exp.head_end)
                    report_mismatch("head_end", o_data.head_end, voice_exp.head_end);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else begin
            if (stall_mode_left == 0) begin
                stall_mode      = t_stall_mode'($urandom_range(0, 3));
                stall_mode_left = $urandom_range(64, 300);
                stall_run       = 0;
            end
            stall_mode_left--;
            stall_phase = (stall_phase + 1) % 3;
            case (stall_mode)
                SM_OPEN: begin
                    i_stall = 1'b0;
                end
                SM_RANDOM: begin
                    i_stall = ($urandom_range(0, 2) == 0);
                end
                SM_EVERY_THIRD: begin
                    i_stall = (stall_phase == 0);
                end
                default: begin
                    if (stall_run > 0) begin
                        i_stall = 1'b1;
                        stall_run--;
                    end else begin
                        i_stall = 1'b0;
                        if ($urandom_range(0, 7) == 0)
                            stall_run = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    initial begin
        t_dir_row           row;
        logic [FRAME_W-1:0] base;
        logic [FRAME_W-1:0] thr;
        int                 span;
        int                 ph;
        int                 n;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data          = '0;
        i_stall         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        mismatch_cnt    = 0;
        cycle_cnt       = 0;
        burst_left      = 0;
        stall_mode      = SM_OPEN;
        stall_mode_left = 0;
        stall_run       = 0;
        stall_phase     = 0;
        voice_cnt       = 0;
        voice_thresh    = '0;
        for (n = 0; n < DEPTH; n++) begin
            voice_cur[n] = '0;
            voice_end[n] = '0;
        end

        // empty list, extremes, duplicate, full list, tail drop
        dir_table.push_back(thresh_row(16'd0));
        dir_table.push_back(known(item_row(CMD_TICK, 16'd0, 16'd0), ST_TICK, 0, 0, 0));
        dir_table.push_back(known(item_row(CMD_PLAY, 16'd0, 16'd0), ST_INSERTED, 1, 0, 0));
        dir_table.push_back(known(item_row(CMD_TICK, 16'hFFFF, 16'hFFFF), ST_TICK, 0, 0, 0));
        dir_table.push_back(known(item_row(CMD_PLAY, 16'hFFFF, 16'hFFFF), ST_INSERTED, 1,
                                  16'hFFFF, 16'hFFFF));
        dir_table.push_back(known(item_row(CMD_PLAY, 16'd0, 16'hFFFF), ST_DUPLICATE, 1,
                                  16'hFFFF, 16'hFFFF));
        dir_table.push_back(item_row(CMD_PLAY, 16'd6995, 16'd7000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd5999, 16'd6000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd5000, 16'd5000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd3998, 16'd4000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd2997, 16'd3000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd1996, 16'd2000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd999, 16'd1000));
        dir_table.push_back(known(item_row(CMD_PLAY, 16'd1, 16'd1), ST_NO_SLOT, 8,
                                  16'hFFFF, 16'hFFFF));
        dir_table.push_back(item_row(CMD_PLAY, 16'd6495, 16'd6500));
        dir_table.push_back(item_row(CMD_TICK, 16'd0, 16'd0));
        // start above end: wraps before removal
        dir_table.push_back(item_row(CMD_PLAY, 16'd10, 16'd5));
        // low-priority request and low-priority head
        dir_table.push_back(thresh_row(16'hFFFF));
        dir_table.push_back(item_row(CMD_PLAY, 16'd0, 16'd40000));
        dir_table.push_back(thresh_row(16'd7000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd7990, 16'd8000));
        dir_table.push_back(item_row(CMD_PLAY, 16'd5, 16'd7000));
        dir_table.push_back(item_row(CMD_TICK, 16'd0, 16'd0));
        dir_table.push_back(thresh_row(16'd0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.kind == ROW_THRESH)
                write_threshold(row.thresh);
            else
                send_item(row.item, row.has_exp, row.exp_res);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            base = 16'($urandom);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 3000)
                                               : $urandom_range(6, 40);
            if (ph == 0)
                thr = 16'd0;
            else if (ph == N_PHASES - 1)
                thr = 16'hFFFF;
            else if (ph == 1)
                thr = 16'($urandom);
            else
                thr = base + 16'($urandom_range(0, span / 3));
            write_threshold(thr);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(voice_request(base, span), 1'b0, '0);
        end

        i_valid = 1'b0;
        while (expected_voice_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (mismatch_cnt == 0 && expected_voice_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
